/* src/yuyv_pkg.sv */
package yuyv_pkg;

  // One YUYV macropixel as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_beat_t;

  // One RGB888 pixel with its framing flags.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_pair;
    logic       end_of_frame;
  } out_pixel_t;

  // A classified macropixel waiting for the color stage.
  typedef struct packed {
    in_beat_t beat;
    logic     single_pixel;  // first pixel ends the frame, second luma is dropped
    logic     eof_second;    // second pixel ends the frame
  } queue_entry_t;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam int unsigned DIM_W   = 12;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned SUM_W   = 18;

  localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 12'd480;
  localparam logic [COUNT_W-1:0] FRAME_TOTAL_RST  = 24'd307200;

  localparam logic signed [SUM_W-1:0] COEF_R_V      = 18'sd359;
  localparam logic signed [SUM_W-1:0] COEF_G_U      = 18'sd88;
  localparam logic signed [SUM_W-1:0] COEF_G_V      = 18'sd183;
  localparam logic signed [SUM_W-1:0] COEF_B_U      = 18'sd454;
  localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 18'sd128;
  localparam logic [7:0]              CHAN_MAX      = 8'd255;

endpackage

/* src/yuyv_cfg_regs.sv */
module yuyv_cfg_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [23:0] frame_total
);
  import yuyv_pkg::*;

  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               wr_en;
  cfg_reg_t           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_t'(paddr[2]);

  // The frame total is formed with the incoming value at write time, so it
  // is ready at the edge right after the write.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    total_nxt  = total_r;
    if (wr_en) begin
      case (reg_sel)
        REG_FRAME_WIDTH: begin
          width_nxt = pwdata[DIM_W-1:0];
          total_nxt = pwdata[DIM_W-1:0] * height_r;
        end
        REG_FRAME_HEIGHT: begin
          height_nxt = pwdata[DIM_W-1:0];
          total_nxt  = width_r * pwdata[DIM_W-1:0];
        end
        default: begin
          total_nxt = total_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
      total_r  <= FRAME_TOTAL_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      total_r  <= total_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = {20'd0, width_r};
      REG_FRAME_HEIGHT: prdata = {20'd0, height_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign frame_total = total_r;

endmodule

/* src/yuyv_front.sv */
module yuyv_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  yuyv_pkg::in_beat_t      in_data,
  input  logic [23:0]             frame_total,
  input  logic                    queue_full,
  output logic                    push,
  output yuyv_pkg::queue_entry_t  push_entry
);
  import yuyv_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W:0]   next_one;
  logic [COUNT_W:0]   next_two;
  logic               eof_first;
  logic               eof_second;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // Both pixel positions of the macropixel are checked against the total
  // at once; the extra bit keeps the compare honest at the counter's top.
  assign next_one   = {1'b0, count_r} + (COUNT_W+1)'(1);
  assign next_two   = {1'b0, count_r} + (COUNT_W+1)'(2);
  assign eof_first  = next_one >= {1'b0, frame_total};
  assign eof_second = next_two >= {1'b0, frame_total};

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      if (eof_first || eof_second) begin
        count_nxt = '0;
      end else begin
        count_nxt = next_two[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign push_entry.beat         = in_data;
  assign push_entry.single_pixel = eof_first;
  assign push_entry.eof_second   = eof_second;

endmodule

/* src/yuyv_queue.sv */
module yuyv_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  yuyv_pkg::queue_entry_t push_entry,
  input  logic                   pop,
  output logic                   full,
  output logic                   not_empty,
  output yuyv_pkg::queue_entry_t head
);
  import yuyv_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  queue_entry_t     slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full      = fill_r == FULL_CNT;
  assign not_empty = fill_r != '0;
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + CNT_W'(1);
      2'b01:   fill_nxt = fill_r - CNT_W'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* src/yuyv_back.sv */
module yuyv_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  yuyv_pkg::queue_entry_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output yuyv_pkg::out_pixel_t   out_data
);
  import yuyv_pkg::*;

  logic                    phase_r, phase_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_pixel_t              pixel_r, pixel_nxt;
  logic                    load;
  logic [7:0]              luma;
  logic signed [SUM_W-1:0] y_s, u_s, v_s;
  logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;

  function automatic logic [7:0] saturate(input logic signed [SUM_W-1:0] s);
    logic [7:0] res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (s[SUM_W-2]) begin
      res = CHAN_MAX;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && (phase_r || head.single_pixel);

  assign luma = phase_r ? head.beat.luma_second : head.beat.luma_first;
  assign y_s  = $signed({2'b00, luma, 8'h00});
  assign u_s  = $signed({10'd0, head.beat.chroma_blue}) - CHROMA_OFFSET;
  assign v_s  = $signed({10'd0, head.beat.chroma_red}) - CHROMA_OFFSET;

  assign sum_r = y_s + COEF_R_V * v_s;
  assign sum_g = y_s - COEF_G_U * u_s - COEF_G_V * v_s;
  assign sum_b = y_s + COEF_B_U * u_s;

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    pixel_nxt     = pixel_r;
    if (load) begin
      out_valid_nxt          = 1'b1;
      phase_nxt              = !pop;
      pixel_nxt.red          = saturate(sum_r);
      pixel_nxt.green        = saturate(sum_g);
      pixel_nxt.blue         = saturate(sum_b);
      pixel_nxt.last_of_pair = phase_r || head.single_pixel;
      pixel_nxt.end_of_frame = phase_r ? head.eof_second : head.single_pixel;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = pixel_r;

endmodule

/* src/yuyv_to_rgb_stream_converter.sv */
// YUYV 4:2:2 to RGB888 stream converter. Each input beat carries one packed
// macropixel (first luma, U, second luma, V) and yields two RGB888 output
// beats that share the chroma, computed as R = (256Y + 359V) >> 8,
// G = (256Y - 88U - 183V) >> 8 and B = (256Y + 454U) >> 8 with U and V
// taken relative to 128, an arithmetic shift and saturation to 0..255.
// A pixel counter runs against frame_width * frame_height (APB registers
// at byte addresses 0 and 4, reset 640 and 480); the last pixel of a frame
// carries end_of_frame, and when the frame total is odd the final
// macropixel gives only its first pixel. Every output beat is flagged
// last_of_pair when it is the final pixel of its macropixel. The converter
// delivers one pixel per cycle while the queue holds a macropixel and the
// output is not stalled, a rate set by the single color datapath behind
// the queue. An accepted macropixel is queued and its pixels leave through
// the output register. Write the registers only while the stream is idle.
module yuyv_to_rgb_stream_converter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  yuyv_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output yuyv_pkg::out_pixel_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import yuyv_pkg::*;

  logic [COUNT_W-1:0] frame_total;
  logic               push;
  logic               pop;
  logic               queue_full;
  logic               head_valid;
  queue_entry_t       push_entry;
  queue_entry_t       head;

  // Register file; it also keeps the frame total as a registered product so
  // the front end only has to compare against it.
  yuyv_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .frame_total (frame_total)
  );

  // The front end accepts a macropixel whenever the queue has room and
  // decides up front whether it ends the frame on its first or second
  // pixel, advancing the pixel counter by two or clearing it at frame end.
  yuyv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .frame_total (frame_total),
    .queue_full  (queue_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  // The queue decouples input acceptance from output backpressure, so new
  // macropixels keep flowing while the back end still drains a pair.
  yuyv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (head_valid),
    .head       (head)
  );

  // The back end walks each queued macropixel one pixel per cycle, while
  // the output is not stalled, through the color math into the output
  // register, popping the entry on its last pixel.
  yuyv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* src/yuyv_checker.sv */
module yuyv_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input yuyv_pkg::out_pixel_t out_data
);
  import yuyv_pkg::*;

  // A stalled output beat holds its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // The second pixel of a pair follows right after the first is taken.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_pair |=> out_valid)
    else $error("second pixel of a pair not presented");

  // A frame always ends on the final pixel of a macropixel.
  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_frame |-> out_data.last_of_pair)
    else $error("end of frame inside a pair");

  // Nothing is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An input beat that is held off stays offered until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input beat withdrawn before it was taken");

endmodule

bind yuyv_to_rgb_stream_converter yuyv_checker u_yuyv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import yuyv_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_pixel_t  out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  yuyv_to_rgb_stream_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Predictor state: a private copy of the frame registers and of the
  // pixel counter, plus the pixels still owed by the converter.
  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic [23:0] pixel_count;
  out_pixel_t  expected_pixels[$];
  int          mismatch_count;

  // Knobs shared between the test tasks and the receiver process.
  bit sender_idling;
  bit receiver_idling;
  int receiver_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net: the slowest legal run is far below this.
  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [7:0] saturate(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  // One pixel from its luma and the shared, already centered chroma. The
  // shifts are on signed ints, so they round toward minus infinity.
  function automatic out_pixel_t rgb_pixel(input logic [7:0] luma, input int u,
                                           input int v, input logic last_pair,
                                           input logic eof);
    out_pixel_t px;
    int         y;
    y = int'(luma) <<< 8;
    px.red          = saturate((y + 359 * v) >>> 8);
    px.green        = saturate((y - 88 * u - 183 * v) >>> 8);
    px.blue         = saturate((y + 454 * u) >>> 8);
    px.last_of_pair = last_pair;
    px.end_of_frame = eof;
    return px;
  endfunction

  // Steps the frame counter by one pixel and tells whether that pixel closes
  // the frame. A counter already at or past the total (after the frame was
  // shrunk) also closes it, and a zero total closes every pixel.
  function automatic bit count_pixel();
    int unsigned total;
    int unsigned next;
    total = int'(frame_width) * int'(frame_height);
    next  = int'(pixel_count) + 1;
    if (next >= total) begin
      pixel_count = '0;
      return 1'b1;
    end
    pixel_count = next[23:0];
    return 1'b0;
  endfunction

  // Pushes the pixels that one accepted macropixel must produce. When the
  // first pixel ends the frame the second luma is dropped.
  function automatic void predict_pixels(input in_beat_t beat);
    int u;
    int v;
    bit eof;
    u = int'(beat.chroma_blue) - 128;
    v = int'(beat.chroma_red) - 128;
    eof = count_pixel();
    if (eof) begin
      expected_pixels.push_back(rgb_pixel(beat.luma_first, u, v, 1'b1, 1'b1));
    end else begin
      expected_pixels.push_back(rgb_pixel(beat.luma_first, u, v, 1'b0, 1'b0));
      eof = count_pixel();
      expected_pixels.push_back(rgb_pixel(beat.luma_second, u, v, 1'b1, eof));
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Bytes lean toward the rails so that saturation is hit often.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_beat_t random_macropixel();
    in_beat_t beat;
    beat.luma_first  = random_byte();
    beat.chroma_blue = random_byte();
    beat.luma_second = random_byte();
    beat.chroma_red  = random_byte();
    return beat;
  endfunction

  // Offers one beat and returns at the edge where it is taken. Valid is only
  // dropped for an idle burst, never between two back-to-back beats.
  task automatic send_macropixel(input in_beat_t beat);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    predict_pixels(beat);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_macropixel(random_macropixel());
  endtask

  // Stops offering beats and waits until every owed pixel has come out,
  // then lets the pipeline settle.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Output check helper
  // ---------------------------------------------------------------------

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // APB write: setup cycle, then access cycle. The register takes the value
  // at the edge that closes the access phase, and so does the predictor.
  // Bits above the register width are filled with noise. Once the access
  // phase closes, the read data for the same address must show the new value.
  task automatic write_frame_reg(input cfg_reg_t which, input logic [11:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= {20'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (which)
      REG_FRAME_WIDTH:  frame_width  = value;
      REG_FRAME_HEIGHT: frame_height = value;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    compare_field("prdata", int'({20'd0, value}), int'(prdata));
  endtask

  task automatic set_frame(input logic [11:0] width, input logic [11:0] height);
    wait_until_idle();
    write_frame_reg(REG_FRAME_WIDTH, width);
    write_frame_reg(REG_FRAME_HEIGHT, height);
  endtask

  // ---------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------

  // Rails and midpoints of all four bytes under the reset frame size, so
  // the counter never reaches the end of the frame here.
  task automatic test_color_extremes();
    in_beat_t beat;
    send_macropixel('0);
    send_macropixel('1);
    send_macropixel({8'd255, 8'd0, 8'd0, 8'd255});
    send_macropixel({8'd0, 8'd255, 8'd255, 8'd0});
    send_macropixel({8'd128, 8'd128, 8'd128, 8'd128});
    send_macropixel({8'd0, 8'd128, 8'd255, 8'd128});
    send_macropixel({8'd16, 8'd0, 8'd235, 8'd255});
    send_macropixel({8'd235, 8'd255, 8'd16, 8'd0});
    beat = {8'd127, 8'd129, 8'd1, 8'd127};
    send_macropixel(beat);
  endtask

  // Odd totals, a one pixel frame, zero totals on either register, the
  // largest frame, and a frame shrunk below where the counter already is.
  task automatic test_frame_sizes();
    set_frame(12'd3, 12'd1);
    send_random(4);
    set_frame(12'd1, 12'd1);
    send_random(2);
    set_frame(12'd0, 12'd7);
    send_random(2);
    set_frame(12'd5, 12'd0);
    send_random(1);
    set_frame(12'd4095, 12'd4095);
    send_random(3);
    // Counter now sits at 6; a total of 4 forces the next pixel to close
    // the frame.
    set_frame(12'd2, 12'd2);
    send_random(3);
  endtask

  // Many short frames of random size with random content. Most frames are
  // tiny so that end of frame and the single pixel case come up often; a
  // few are wide to move every bit of the width register.
  task automatic test_random_frames(input int items);
    int sent;
    int burst;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 7) == 0)
        set_frame(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 2)));
      else
        set_frame(12'($urandom_range(1, 9)), 12'($urandom_range(1, 5)));
      burst = $urandom_range(8, 40);
      send_random(burst);
      sent += burst;
    end
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // the converter fills up and has to drop in_ready.
  task automatic test_backpressure();
    sender_idling = 1'b0;
    receiver_hold = 250;
    send_random(40);
    sender_idling = 1'b1;
  endtask

  // The sender goes quiet until everything owed has come out, then resumes
  // in the middle of the same frame.
  task automatic test_sender_pause();
    set_frame(12'd7, 12'd3);
    send_random(15);
    wait_until_idle();
    send_random(15);
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_steady_stream();
    set_frame(12'd9, 12'd3);
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    send_random(120);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random ready pattern, plus a long hold on request
  // ---------------------------------------------------------------------

  initial begin
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (receiver_hold > 0) begin
        out_ready <= 1'b0;
        repeat (receiver_hold) @(posedge clk);
        receiver_hold = 0;
      end else if (receiver_idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output check: every accepted beat against the oldest owed pixel
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    out_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $time, out_data);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        compare_field("red", int'(want.red), int'(out_data.red));
        compare_field("green", int'(want.green), int'(out_data.green));
        compare_field("blue", int'(want.blue), int'(out_data.blue));
        compare_field("last_of_pair", int'(want.last_of_pair),
                      int'(out_data.last_of_pair));
        compare_field("end_of_frame", int'(want.end_of_frame),
                      int'(out_data.end_of_frame));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    int settle;
    mismatch_count  = 0;
    sender_idling   = 1'b1;
    receiver_idling = 1'b1;
    receiver_hold   = 0;
    frame_width     = 12'd640;
    frame_height    = 12'd480;
    pixel_count     = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_color_extremes();
    test_frame_sizes();
    test_random_frames(420);
    test_backpressure();
    test_sender_pause();
    test_random_frames(420);
    test_steady_stream();

    // Drain: every owed pixel must come out, then the bench keeps watching to
    // catch anything extra.
    in_valid <= 1'b0;
    settle = 0;
    while (expected_pixels.size() != 0 && settle < 2000) begin
      @(posedge clk);
      settle++;
    end
    repeat (10) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d pixels never arrived, expected 0 left, actual %0d", $time,
               expected_pixels.size(), expected_pixels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* yuyv_to_rgb_stream_converter.f */
src/yuyv_pkg.sv
src/yuyv_cfg_regs.sv
src/yuyv_front.sv
src/yuyv_queue.sv
src/yuyv_back.sv
src/yuyv_to_rgb_stream_converter.sv
src/yuyv_checker.sv
tb/testbench.sv
